>>> rtl/sml_tl_stream_parser_core_defines.svh
// Assertion macros used by the top level of the SML type-length parser.
`ifndef SML_TL_STREAM_PARSER_CORE_DEFINES_SVH
`define SML_TL_STREAM_PARSER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SML_TL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SML_TL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sml_tl_pkg.sv
// Types and constants shared by the SML type-length parser modules.
`default_nettype none

package sml_tl_pkg;

    // Event kinds reported with every byte.
    localparam logic [2:0] EV_IGNORED = 3'd0;
    localparam logic [2:0] EV_HEADER  = 3'd1;
    localparam logic [2:0] EV_VALUE   = 3'd2;
    localparam logic [2:0] EV_EOM     = 3'd3;
    localparam logic [2:0] EV_FILL    = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_DEPTH = 2'd2;
    localparam logic [1:0] ERR_LEN   = 2'd3;

    // SML type code that marks a list.
    localparam logic [2:0] TYPE_LIST = 3'd7;

    // Operation on the list stack for one byte.
    typedef enum logic [1:0] {
        STK_NONE,
        STK_CLOSE,
        STK_OPEN_PLAIN,
        STK_OPEN_EXT
    } stk_op_t;

    // Operation on the pending header and value counters for one byte.
    typedef enum logic [2:0] {
        VAL_NONE,
        VAL_HOLD_EXT,
        VAL_START_PLAIN,
        VAL_START_EXT,
        VAL_STEP
    } val_op_t;

    // Source of the reported node type.
    typedef enum logic [1:0] {
        NT_ZERO,
        NT_BYTE,
        NT_PEND
    } nt_sel_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic       load;
        stk_op_t    stk;
        val_op_t    val;
        logic [2:0] ev;
        nt_sel_t    nt_sel;
        logic       show_depth;
        logic       done;
        logic [1:0] err;
    } ctl_cmd_t;

    // Decode and stack status from the datapath to the controller.
    typedef struct packed {
        logic byte_zero;
        logic type_ext;
        logic type_list;
        logic len_zero;
        logic len_one;
        logic depth_zero;
        logic depth_full;
        logic pend_list;
        logic ext_len_zero;
        logic ext_len_lt2;
        logic ext_len_eq2;
        logic rem_last;
        logic close_left_nz;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/sml_tl_stream_parser_core.sv
// Top level of the SML type-length stream parser.
//
// The block takes an SML file one byte per request on the s_ channel, with
// s_frame_start on the first byte of a file and s_frame_end on the last byte
// of the buffer. For every accepted request it returns exactly one result
// request on the m_ channel that tags the byte: header, value byte,
// end-of-message marker, fill stop or ignored, with the list depth, node type,
// value index, node completion, the number of lists closed and an error code.
// The result of a byte is presented in the cycle after it is accepted.
// Throughput is one byte per cycle while the receiver does not stall; the
// whole decode and the cascaded list close over the MAX_DEPTH-entry stack are combinational.
// The result sits in an output register, so a new byte is accepted while the
// previous result is being taken. When the receiver stalls, s_ready drops
// and the held result stays unchanged until m_ready is seen.
// A synchronous reset (aresetn low) empties the output register and returns
// the parser to expecting a header at depth zero. After an error, a fill byte
// or the last byte of a buffer the parser reports every byte as ignored until
// a request with s_frame_start arrives.
`default_nettype none

`include "sml_tl_stream_parser_core_defines.svh"

module sml_tl_stream_parser_core
    import sml_tl_pkg::*;
#(
    parameter int MAX_DEPTH = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_frame_start,
    input  wire logic       s_frame_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_event_kind,
    output logic [3:0]      m_nest_depth,
    output logic [2:0]      m_node_type,
    output logic [7:0]      m_value_byte,
    output logic [7:0]      m_value_index,
    output logic            m_node_done,
    output logic [3:0]      m_lists_closed,
    output logic [1:0]      m_error_code
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    // The controller tracks the parse phase and the handshake; it turns the
    // decode status into one command per accepted byte.
    sml_tl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_frame_start (s_frame_start),
        .s_frame_end   (s_frame_end),
        .m_ready       (m_ready),
        .status        (status),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .cmd           (cmd)
    );

    // The datapath decodes the byte, keeps the stack of remaining child
    // counts and holds the result register.
    sml_tl_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data_byte    (s_data_byte),
        .s_frame_start  (s_frame_start),
        .cmd            (cmd),
        .status         (status),
        .m_event_kind   (m_event_kind),
        .m_nest_depth   (m_nest_depth),
        .m_node_type    (m_node_type),
        .m_value_byte   (m_value_byte),
        .m_value_index  (m_value_index),
        .m_node_done    (m_node_done),
        .m_lists_closed (m_lists_closed),
        .m_error_code   (m_error_code)
    );

    // Every accepted byte produces a result in the next cycle.
    `SML_TL_ASSERT_NEXT(a_accept_gives_result, s_valid && s_ready, m_valid, "accepted byte gave no result")

    // An ignored byte carries no other information.
    `SML_TL_ASSERT_SAME(a_ignored_is_blank, m_valid && (m_event_kind == EV_IGNORED), (m_nest_depth == 4'd0) && (m_node_type == 3'd0) && (m_value_byte == 8'd0) && (m_lists_closed == 4'd0) && !m_node_done && (m_error_code == ERR_NONE), "ignored byte has nonzero fields")

    // Lists only close when a node completes.
    `SML_TL_ASSERT_SAME(a_close_needs_done, m_valid && (m_lists_closed != 4'd0), m_node_done, "lists closed without a completed node")

    // A value byte can only report truncation.
    `SML_TL_ASSERT_SAME(a_value_error, m_valid && (m_event_kind == EV_VALUE), (m_error_code == ERR_NONE) || (m_error_code == ERR_TRUNC), "value byte reported a header error")

endmodule

`default_nettype wire

>>> rtl/sml_tl_ctrl.sv
// Parse-phase controller and output handshake of the SML type-length parser.
`default_nettype none

module sml_tl_ctrl
    import sml_tl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_frame_start,
    input  wire logic       s_frame_end,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output logic            s_ready,
    output logic            m_valid,
    output ctl_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_EXT,
        ST_VALUE,
        ST_STOPPED
    } state_t;

    state_t state_reg, state_next, eff_state, parse_next, final_state;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   stop_req;
    logic   depth_after_nz;

    always_comb begin
        s_ready   = !m_valid_reg || m_ready;
        accept    = s_valid && s_ready;
        // A frame start clears the parser before the byte is decoded.
        eff_state = s_frame_start ? ST_HEADER : state_reg;

        cmd.load       = accept;
        cmd.stk        = STK_NONE;
        cmd.val        = VAL_NONE;
        cmd.ev         = EV_IGNORED;
        cmd.nt_sel     = NT_ZERO;
        cmd.show_depth = 1'b0;
        cmd.done       = 1'b0;
        cmd.err        = ERR_NONE;
        parse_next     = eff_state;
        stop_req       = 1'b0;

        unique case (eff_state)
            ST_HEADER: begin
                cmd.show_depth = 1'b1;
                if (status.byte_zero && status.depth_zero) begin
                    cmd.ev   = EV_FILL;
                    stop_req = 1'b1;
                end else begin
                    cmd.ev     = EV_HEADER;
                    cmd.nt_sel = NT_BYTE;
                    priority if (status.type_ext) begin
                        cmd.val    = VAL_HOLD_EXT;
                        parse_next = ST_EXT;
                    end else if (status.byte_zero) begin
                        cmd.ev   = EV_EOM;
                        cmd.done = 1'b1;
                        cmd.stk  = STK_CLOSE;
                    end else if (status.type_list) begin
                        priority if (status.len_zero) begin
                            cmd.done = 1'b1;
                            cmd.stk  = STK_CLOSE;
                        end else if (status.depth_full) begin
                            cmd.err = ERR_DEPTH;
                        end else begin
                            cmd.stk = STK_OPEN_PLAIN;
                        end
                    end else if (status.len_zero) begin
                        cmd.err = ERR_LEN;
                    end else if (status.len_one) begin
                        cmd.done = 1'b1;
                        cmd.stk  = STK_CLOSE;
                    end else begin
                        cmd.val    = VAL_START_PLAIN;
                        parse_next = ST_VALUE;
                    end
                end
            end
            ST_EXT: begin
                cmd.show_depth = 1'b1;
                cmd.ev         = EV_HEADER;
                cmd.nt_sel     = NT_PEND;
                parse_next     = ST_HEADER;
                if (status.pend_list) begin
                    priority if (status.ext_len_zero) begin
                        cmd.done = 1'b1;
                        cmd.stk  = STK_CLOSE;
                    end else if (status.depth_full) begin
                        cmd.err = ERR_DEPTH;
                    end else begin
                        cmd.stk = STK_OPEN_EXT;
                    end
                end else begin
                    priority if (status.ext_len_lt2) begin
                        cmd.err = ERR_LEN;
                    end else if (status.ext_len_eq2) begin
                        cmd.done = 1'b1;
                        cmd.stk  = STK_CLOSE;
                    end else begin
                        cmd.val    = VAL_START_EXT;
                        parse_next = ST_VALUE;
                    end
                end
            end
            ST_VALUE: begin
                cmd.show_depth = 1'b1;
                cmd.ev         = EV_VALUE;
                cmd.nt_sel     = NT_PEND;
                cmd.val        = VAL_STEP;
                if (status.rem_last) begin
                    cmd.done   = 1'b1;
                    cmd.stk    = STK_CLOSE;
                    parse_next = ST_HEADER;
                end
            end
            ST_STOPPED: begin
                parse_next = ST_STOPPED;
            end
        endcase

        unique case (cmd.stk)
            STK_CLOSE:                    depth_after_nz = status.close_left_nz;
            STK_OPEN_PLAIN, STK_OPEN_EXT: depth_after_nz = 1'b1;
            STK_NONE:                     depth_after_nz = !status.depth_zero;
        endcase

        final_state = parse_next;
        if (eff_state != ST_STOPPED) begin
            if (cmd.err != ERR_NONE) begin
                final_state = ST_STOPPED;
            end else if (s_frame_end && (parse_next != ST_HEADER || depth_after_nz)) begin
                cmd.err = ERR_TRUNC;
            end
            if (s_frame_end || stop_req) begin
                final_state = ST_STOPPED;
            end
        end

        state_next   = accept ? final_state : state_reg;
        m_valid_next = accept ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_valid      = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_HEADER;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sml_tl_dp.sv
// Datapath of the SML type-length parser: header decode, list stack and result registers.
`default_nettype none

module sml_tl_dp
    import sml_tl_pkg::*;
#(
    parameter int MAX_DEPTH = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_frame_start,
    input  wire ctl_cmd_t   cmd,
    output dp_status_t      status,
    output logic [2:0]      m_event_kind,
    output logic [3:0]      m_nest_depth,
    output logic [2:0]      m_node_type,
    output logic [7:0]      m_value_byte,
    output logic [7:0]      m_value_index,
    output logic            m_node_done,
    output logic [3:0]      m_lists_closed,
    output logic [1:0]      m_error_code
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic [DW-1:0] depth_reg, depth_next, eff_depth;
    logic [DW-1:0] close_depth, closed_cnt;
    logic [7:0]    child_reg  [MAX_DEPTH];
    logic [7:0]    child_next [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] closes;
    logic          chain;

    logic [2:0] pend_type_reg, pend_type_next;
    logic [3:0] pend_len_reg, pend_len_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] pos_reg, pos_next;

    logic [3:0] byte_len;
    logic [2:0] byte_type;
    logic [7:0] ext_len;
    logic [7:0] open_len;

    logic [2:0] ev_reg;
    logic [3:0] dep_reg;
    logic [2:0] nt_reg;
    logic [7:0] vb_reg;
    logic [7:0] vi_reg;
    logic       done_reg;
    logic [3:0] closed_reg;
    logic [1:0] err_reg;
    logic [2:0] nt_out;

    always_comb begin
        byte_len  = s_data_byte[3:0];
        byte_type = s_data_byte[6:4];
        ext_len   = {pend_len_reg, byte_len};
        eff_depth = s_frame_start ? '0 : depth_reg;

        // Lists close from the top of the stack down while their last child is counted.
        chain  = 1'b1;
        closes = '0;
        for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
            if (DW'(i) < eff_depth) begin
                chain     = chain && (child_reg[i] == 8'd1);
                closes[i] = chain;
            end
        end
        close_depth = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if ((DW'(i) < eff_depth) && !closes[i]) begin
                close_depth = DW'(i + 1);
            end
        end
        closed_cnt = eff_depth - close_depth;

        status.byte_zero     = (s_data_byte == 8'd0);
        status.type_ext      = s_data_byte[7];
        status.type_list     = (byte_type == TYPE_LIST);
        status.len_zero      = (byte_len == 4'd0);
        status.len_one       = (byte_len == 4'd1);
        status.depth_zero    = (eff_depth == '0);
        status.depth_full    = (eff_depth >= DW'(MAX_DEPTH));
        status.pend_list     = (pend_type_reg == TYPE_LIST);
        status.ext_len_zero  = (ext_len == 8'd0);
        status.ext_len_lt2   = (ext_len < 8'd2);
        status.ext_len_eq2   = (ext_len == 8'd2);
        status.rem_last      = (rem_reg == 8'd1);
        status.close_left_nz = (close_depth != '0);

        open_len = (cmd.stk == STK_OPEN_PLAIN) ? {4'd0, byte_len} : ext_len;

        for (int i = 0; i < MAX_DEPTH; i++) begin
            child_next[i] = child_reg[i];
            unique case (cmd.stk)
                STK_CLOSE: begin
                    if (closes[i]) begin
                        child_next[i] = 8'd0;
                    end else if (DW'(i + 1) == close_depth) begin
                        child_next[i] = child_reg[i] - 8'd1;
                    end
                end
                STK_OPEN_PLAIN, STK_OPEN_EXT: begin
                    if (DW'(i) == eff_depth) begin
                        child_next[i] = open_len;
                    end
                end
                STK_NONE: begin
                end
            endcase
        end

        unique case (cmd.stk)
            STK_CLOSE:                    depth_next = close_depth;
            STK_OPEN_PLAIN, STK_OPEN_EXT: depth_next = eff_depth + DW'(1);
            STK_NONE:                     depth_next = eff_depth;
        endcase

        pend_type_next = pend_type_reg;
        pend_len_next  = pend_len_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        unique case (cmd.val)
            VAL_HOLD_EXT: begin
                pend_type_next = byte_type;
                pend_len_next  = byte_len;
            end
            VAL_START_PLAIN: begin
                pend_type_next = byte_type;
                rem_next       = {4'd0, byte_len} - 8'd1;
                pos_next       = 8'd0;
            end
            VAL_START_EXT: begin
                rem_next = ext_len - 8'd2;
                pos_next = 8'd0;
            end
            VAL_STEP: begin
                rem_next = rem_reg - 8'd1;
                pos_next = pos_reg + 8'd1;
            end
            default: begin
            end
        endcase

        unique case (cmd.nt_sel)
            NT_BYTE: nt_out = byte_type;
            NT_PEND: nt_out = pend_type_reg;
            default: nt_out = 3'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else if (cmd.load) begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            child_reg     <= child_next;
            pend_type_reg <= pend_type_next;
            pend_len_reg  <= pend_len_next;
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            ev_reg        <= cmd.ev;
            dep_reg       <= cmd.show_depth ? 4'(eff_depth) : 4'd0;
            nt_reg        <= nt_out;
            vb_reg        <= (cmd.val == VAL_STEP) ? s_data_byte : 8'd0;
            vi_reg        <= (cmd.val == VAL_STEP) ? pos_reg : 8'd0;
            done_reg      <= cmd.done;
            closed_reg    <= (cmd.stk == STK_CLOSE) ? 4'(closed_cnt) : 4'd0;
            err_reg       <= cmd.err;
        end
    end

    assign m_event_kind   = ev_reg;
    assign m_nest_depth   = dep_reg;
    assign m_node_type    = nt_reg;
    assign m_value_byte   = vb_reg;
    assign m_value_index  = vi_reg;
    assign m_node_done    = done_reg;
    assign m_lists_closed = closed_reg;
    assign m_error_code   = err_reg;

endmodule

`default_nettype wire
